/* rtl/core/csb_pkg.sv */
// Shared types and constants for the cursor sequence buffer.
package csb_pkg;

	// Store geometry
	localparam int DEPTH     = 64;
	localparam int ITEM_BITS = 8;
	localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// Field widths of the command and response items
	localparam int MODE_W  = 3;
	localparam int ENTRY_W = 8;
	localparam int ITEM_W  = 8;
	localparam int COUNT_W = 7;
	localparam int ERR_W   = 2;

	typedef logic [ITEM_BITS-1:0] word_t;
	typedef logic [ITEM_W-1:0]    item_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// Command codes; the two unused codes act as query
	typedef enum logic [MODE_W-1:0] {
		MODE_START   = 3'd0,
		MODE_ADVANCE = 3'd1,
		MODE_APPEND  = 3'd2,
		MODE_INSERT  = 3'd3,
		MODE_REMOVE  = 3'd4,
		MODE_QUERY   = 3'd5
	} mode_e;

	// Error codes
	typedef enum logic [ERR_W-1:0] {
		ERR_OK   = 2'd0,
		ERR_FULL = 2'd1,
		ERR_NONE = 2'd2
	} err_e;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ENTRY_W-1:0] entry;
	} cmd_t;

	typedef struct packed {
		logic [ITEM_W-1:0]  item;
		logic               has_item;
		logic [COUNT_W-1:0] count;
		logic [ERR_W-1:0]   error;
	} rsp_t;

endpackage

/* rtl/core/csb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module csb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/cursor_sequence_buffer.sv */
// Top level of the cursor sequence buffer: control sequencer around one item store RAM.
//
//   channel  direction  handshake            payload
//   cmd      in         cmd_valid/cmd_ready  csb_pkg::cmd_t (mode, entry)
//   rsp      out        rsp_valid/rsp_ready  csb_pkg::rsp_t (item, has_item, count, error)
//
// One command is worked at a time. Start, advance, append, query and failing
// commands pass through the fetch and wait steps to the response. Insert runs
// shift, put, fetch and wait, remove runs shift, fetch and wait; the shift moves
// items, and the store RAM moves one item per cycle through its single write port.
// Reset clears fill, cursor and control; RAM contents stay undefined, since only
// positions below fill are ever read. A stalled response holds the sequencer
// in its last step; no new command is taken until the response is registered.
module cursor_sequence_buffer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  csb_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output csb_pkg::rsp_t  rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PUT,
		S_FETCH,
		S_WAIT
	} state_t;

	state_t             state_q;
	csb_pkg::cnt_t      fill_q;
	csb_pkg::cnt_t      cursor_q;
	csb_pkg::cnt_t      idx_q;
	logic               ins_q;
	csb_pkg::err_e      err_q;
	csb_pkg::word_t     val_q;
	logic               pw_valid_s1;
	csb_pkg::addr_t     pw_addr_s1;
	logic               rsp_valid_q;
	csb_pkg::rsp_t      rsp_q;

	logic               cmd_fire;
	logic               has_cur;
	logic               full;
	logic               shift_go;
	csb_pkg::cnt_t      shift_rd;
	csb_pkg::word_t     cmd_val;
	logic               rsp_load;

	logic               ram_we;
	csb_pkg::addr_t     ram_waddr;
	csb_pkg::word_t     ram_wdata;
	csb_pkg::addr_t     ram_raddr;
	csb_pkg::word_t     ram_rdata;

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign has_cur = (cursor_q < fill_q);
	assign full    = (fill_q == csb_pkg::CNT_W'(csb_pkg::DEPTH));
	assign cmd_val = csb_pkg::word_t'(cmd.entry);

	// Shift step: insert walks down from the old end, remove walks up from the cursor
	assign shift_go = ins_q ? (idx_q > cursor_q) : (idx_q < fill_q);
	assign shift_rd = ins_q ? (idx_q - csb_pkg::CNT_W'(1)) : (idx_q + csb_pkg::CNT_W'(1));

	assign rsp_load = (state_q == S_WAIT) && (!rsp_valid_q || rsp_ready);

	// Read address: shift source while shifting, else the cursor
	always_comb begin
		if (state_q == S_SHIFT) begin
			ram_raddr = shift_rd[csb_pkg::ADDR_W-1:0];
		end else begin
			ram_raddr = cursor_q[csb_pkg::ADDR_W-1:0];
		end
	end

	// Write port: pending shift write first, then the new item
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pw_addr_s1;
		ram_wdata = ram_rdata;
		if (pw_valid_s1) begin
			ram_we = 1'b1;
		end else if (state_q == S_PUT) begin
			ram_we    = 1'b1;
			ram_waddr = cursor_q[csb_pkg::ADDR_W-1:0];
			ram_wdata = val_q;
		end else if (cmd_fire && (cmd.mode == csb_pkg::MODE_APPEND) && !full) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q[csb_pkg::ADDR_W-1:0];
			ram_wdata = cmd_val;
		end
	end

	csb_ram #(
		.WIDTH (csb_pkg::ITEM_BITS),
		.DEPTH (csb_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: state, cursor, fill and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			ins_q       <= 1'b0;
			err_q       <= csb_pkg::ERR_OK;
			val_q       <= '0;
			pw_valid_s1 <= 1'b0;
			pw_addr_s1  <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// Issue a shift write in the cycle after its read
			pw_valid_s1 <= (state_q == S_SHIFT) && shift_go;

			// Raise the response on load, drop it once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						err_q   <= csb_pkg::ERR_OK;
						val_q   <= cmd_val;
						state_q <= S_FETCH;
						unique case (cmd.mode)
							csb_pkg::MODE_START: begin
								cursor_q <= '0;
							end
							csb_pkg::MODE_ADVANCE: begin
								if (has_cur) begin
									cursor_q <= cursor_q + csb_pkg::CNT_W'(1);
								end else begin
									err_q <= csb_pkg::ERR_NONE;
								end
							end
							csb_pkg::MODE_APPEND: begin
								if (full) begin
									err_q <= csb_pkg::ERR_FULL;
								end else begin
									cursor_q <= fill_q;
									fill_q   <= fill_q + csb_pkg::CNT_W'(1);
								end
							end
							csb_pkg::MODE_INSERT: begin
								if (full) begin
									err_q <= csb_pkg::ERR_FULL;
								end else begin
									if (!has_cur) begin
										cursor_q <= '0;
									end
									idx_q   <= fill_q;
									fill_q  <= fill_q + csb_pkg::CNT_W'(1);
									ins_q   <= 1'b1;
									state_q <= S_SHIFT;
								end
							end
							csb_pkg::MODE_REMOVE: begin
								if (!has_cur) begin
									err_q <= csb_pkg::ERR_NONE;
								end else begin
									idx_q   <= cursor_q;
									fill_q  <= fill_q - csb_pkg::CNT_W'(1);
									ins_q   <= 1'b0;
									state_q <= S_SHIFT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					// Read one source entry; its write lands next cycle
					if (shift_go) begin
						pw_addr_s1  <= idx_q[csb_pkg::ADDR_W-1:0];
						idx_q       <= shift_rd;
					end else begin
						state_q <= ins_q ? S_PUT : S_FETCH;
					end
				end
				S_PUT: begin
					// Write the new item once the last shift write is out
					if (!pw_valid_s1) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					// Read the current item after all writes have landed
					if (!pw_valid_s1) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (rsp_load) begin
						rsp_q.item     <= has_cur ? csb_pkg::item_t'(ram_rdata) : '0;
						rsp_q.has_item <= has_cur;
						rsp_q.count    <= csb_pkg::COUNT_W'(fill_q);
						rsp_q.error    <= err_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* dv/cursor_sequence_buffer_chk.sv */
// Response checker for the cursor sequence buffer: shadows the sequence and compares each response.
`timescale 1ns / 100ps
module cursor_sequence_buffer_chk
	import csb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_ready,
	input  cmd_t cmd,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   full_hits,
	output int   none_hits,
	output int   peak_fill
);

	localparam int REPORT_MAX = 10;

	// shadow copy of the sequence and its cursor
	word_t seq_mem [DEPTH];
	int    seq_len;
	int    seq_pos;

	// responses owed by the block, oldest first
	rsp_t  owed_q [$];
	rsp_t  owed;

	// apply one command to the shadow sequence and return the response it earns
	function automatic rsp_t apply_cmd(cmd_t c);
		word_t val;
		err_e  err;
		bit    has;
		rsp_t  r;
		int    i;
		val = c.entry[ITEM_BITS-1:0];
		err = ERR_OK;
		has = seq_pos < seq_len;
		case (c.mode)
			MODE_START: begin
				seq_pos = 0;
			end
			MODE_ADVANCE: begin
				if (has)
					seq_pos++;
				else
					err = ERR_NONE;
			end
			MODE_APPEND: begin
				if (seq_len >= DEPTH) begin
					err = ERR_FULL;
				end else begin
					seq_mem[seq_len] = val;
					seq_pos = seq_len;
					seq_len++;
				end
			end
			MODE_INSERT: begin
				if (seq_len >= DEPTH) begin
					err = ERR_FULL;
				end else begin
					// with no current item the new one goes in at the front
					if (!has)
						seq_pos = 0;
					for (i = seq_len; i > seq_pos; i--)
						seq_mem[i] = seq_mem[i-1];
					seq_mem[seq_pos] = val;
					seq_len++;
				end
			end
			MODE_REMOVE: begin
				if (!has) begin
					err = ERR_NONE;
				end else begin
					for (i = seq_pos; i + 1 < seq_len; i++)
						seq_mem[i] = seq_mem[i+1];
					seq_len--;
				end
			end
			default: begin
				// query and the spare codes leave everything alone
			end
		endcase
		has = seq_pos < seq_len;
		r.item     = has ? item_t'(seq_mem[seq_pos]) : '0;
		r.has_item = has;
		r.count    = COUNT_W'(seq_len);
		r.error    = err;
		return r;
	endfunction

	// retire responses first, then predict the accepted command
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len = 0;
			seq_pos = 0;
			owed_q.delete();
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (owed_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("[%0t] response with none owed: item %02h has %0b count %0d error %0d",
							$realtime, rsp.item, rsp.has_item, rsp.count, rsp.error);
				end else begin
					owed = owed_q.pop_front();
					checked++;
					if (rsp.item !== owed.item || rsp.has_item !== owed.has_item ||
					    rsp.count !== owed.count || rsp.error !== owed.error) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("[%0t] mismatch: expected item %02h has %0b count %0d error %0d, got item %02h has %0b count %0d error %0d",
								$realtime, owed.item, owed.has_item, owed.count, owed.error,
								rsp.item, rsp.has_item, rsp.count, rsp.error);
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				owed = apply_cmd(cmd);
				owed_q.push_back(owed);
				if (owed.error == ERR_FULL)
					full_hits++;
				if (owed.error == ERR_NONE)
					none_hits++;
				if (seq_len > peak_fill)
					peak_fill = seq_len;
			end
			pending = owed_q.size();
		end
	end

endmodule

/* dv/cursor_sequence_buffer_tb.sv */
// Testbench top for the cursor sequence buffer: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module cursor_sequence_buffer_tb;
	import csb_pkg::*;

	// the two codes above query have no name in the package
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 100;

	typedef enum int {BIAS_GROW, BIAS_WALK, BIAS_SHRINK, BIAS_MIX} bias_e;

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int sent;
	int idle_pct;
	int stall_pct = 0;
	int cycles    = 0;
	int fail_count;
	int pending;
	int checked;
	int full_hits;
	int none_hits;
	int peak_fill;

	cursor_sequence_buffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	cursor_sequence_buffer_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.full_hits  (full_hits),
		.none_hits  (none_hits),
		.peak_fill  (peak_fill)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// stall the response channel at the current rate
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// offer one command, with random idle cycles ahead of it, and hold until taken
	task automatic send_cmd(logic [MODE_W-1:0] m, logic [ENTRY_W-1:0] e);
		while ($urandom_range(0, 99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= '{mode: m, entry: e};
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		sent++;
	endtask

	// pick a command code leaning toward growth, walking or draining, or uniformly at random
	function automatic logic [MODE_W-1:0] pick_mode(bias_e bias);
		int roll;
		roll = $urandom_range(0, 99);
		case (bias)
			BIAS_GROW: begin
				if (roll < 50)      return MODE_APPEND;
				else if (roll < 90) return MODE_INSERT;
				else if (roll < 95) return MODE_ADVANCE;
				else                return MODE_START;
			end
			BIAS_WALK: begin
				if (roll < 45)      return MODE_ADVANCE;
				else if (roll < 55) return MODE_START;
				else if (roll < 70) return MODE_INSERT;
				else if (roll < 85) return MODE_REMOVE;
				else if (roll < 90) return MODE_QUERY;
				else if (roll < 95) return MODE_SPARE6;
				else                return MODE_SPARE7;
			end
			BIAS_SHRINK: begin
				if (roll < 70)      return MODE_REMOVE;
				else if (roll < 82) return MODE_START;
				else if (roll < 92) return MODE_ADVANCE;
				else if (roll < 96) return MODE_APPEND;
				else                return MODE_QUERY;
			end
			default: return MODE_W'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic run_round(bias_e bias, int n);
		for (int k = 0; k < n; k++)
			send_cmd(pick_mode(bias), ENTRY_W'($urandom_range(0, 255)));
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		idle_pct = sender_pct;
		stall_pct <= receiver_pct;
	endtask

	initial begin
		idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, front insertion, cursor at the end, spare codes
		send_cmd(MODE_QUERY,   8'h00);
		send_cmd(MODE_ADVANCE, 8'hFF);
		send_cmd(MODE_REMOVE,  8'hFF);
		send_cmd(MODE_START,   8'h00);
		send_cmd(MODE_INSERT,  8'hFF);
		send_cmd(MODE_APPEND,  8'h00);
		send_cmd(MODE_START,   8'h00);
		send_cmd(MODE_INSERT,  8'hA5);
		send_cmd(MODE_ADVANCE, 8'h00);
		send_cmd(MODE_ADVANCE, 8'h00);
		send_cmd(MODE_ADVANCE, 8'h00);
		send_cmd(MODE_ADVANCE, 8'h00);
		send_cmd(MODE_INSERT,  8'h5A);
		send_cmd(MODE_REMOVE,  8'h00);
		send_cmd(MODE_SPARE6,  8'h33);
		send_cmd(MODE_SPARE7,  8'hCC);
		send_cmd(MODE_APPEND,  8'h80);
		send_cmd(MODE_REMOVE,  8'h00);
		send_cmd(MODE_REMOVE,  8'h00);
		send_cmd(MODE_START,   8'h00);
		send_cmd(MODE_REMOVE,  8'h00);
		send_cmd(MODE_QUERY,   8'hFF);

		// random rounds, each under the idle pattern set just before it
		set_idling(0, 0);
		run_round(BIAS_GROW, 100);
		set_idling(50, 0);
		run_round(BIAS_WALK, 70);
		set_idling(0, 50);
		run_round(BIAS_SHRINK, 90);
		set_idling(29, 29);
		run_round(BIAS_GROW, 100);
		set_idling(0, 0);
		run_round(BIAS_MIX, 90);
		cmd_valid <= 1'b0;

		// drain outstanding responses, then let the block settle
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands: directed edge cases, fill to capacity, cursor walks,",
			sent);
		$display("front drains and mixed codes; %0d responses checked, %0d full, %0d no current, peak fill %0d.",
			checked, full_hits, none_hits, peak_fill);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* cursor_sequence_buffer.f */
rtl/core/csb_pkg.sv
rtl/core/csb_ram.sv
rtl/core/cursor_sequence_buffer.sv
dv/cursor_sequence_buffer_chk.sv
dv/cursor_sequence_buffer_tb.sv
